### rtl/fpcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpcf_pkg: shared types and constants for the frame patch checksum fixup
// Frame layout offsets, register map codes and the configuration bundle.
// ----------------------------------------------------------------------------
package fpcf_pkg;

  localparam int unsigned OFF_W        = 11;
  localparam int unsigned WORD_W       = 16;
  localparam int unsigned ADDR_W       = 5;
  localparam int unsigned DATA_W       = 32;

  // Largest frame in bytes; a word that would end past it is dropped.
  localparam int unsigned MAX_FRAME_BYTES = 2048;
  localparam int unsigned OFF_LIMIT       = MAX_FRAME_BYTES - 2;

  // Frame layout, bytes from the start of the Ethernet header.
  localparam logic [OFF_W-1:0] ETH_HDR_BYTES = OFF_W'(14);
  localparam logic [OFF_W-1:0] IP_CSUM_OFF   = OFF_W'(24);
  localparam logic [OFF_W-1:0] PSEUDO_LO     = OFF_W'(26);
  localparam logic [OFF_W-1:0] PSEUDO_HI     = OFF_W'(34);
  localparam logic [OFF_W-1:0] TCP_CSUM_REL  = OFF_W'(16);
  localparam logic [OFF_W-1:0] UDP_CSUM_REL  = OFF_W'(6);

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_TCP   = 2'd1,
    KIND_UDP   = 2'd2,
    KIND_RSVD  = 2'd3
  } l4_kind_t;

  typedef enum logic [2:0] {
    REG_FRAME_IS_IPV4   = 3'd0,
    REG_IP_HEADER_WORDS = 3'd1,
    REG_L4_KIND         = 3'd2,
    REG_TMPL_IP_CSUM    = 3'd3,
    REG_TMPL_L4_CSUM    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic              frame_is_ipv4;
    logic [3:0]        ip_header_words;
    logic [1:0]        l4_kind;
    logic [WORD_W-1:0] template_ip_checksum;
    logic [WORD_W-1:0] template_l4_checksum;
  } cfg_t;

  typedef struct packed {
    logic              first_of_frame;
    logic [OFF_W-1:0]  offset;
    logic [WORD_W-1:0] old_word;
    logic [WORD_W-1:0] new_word;
  } patch_t;

  typedef struct packed {
    logic [OFF_W-1:0]  offset;
    logic [WORD_W-1:0] word;
    logic              write_enable;
  } wr_t;

endpackage

### rtl/frame_patch_checksum_fixup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_patch_checksum_fixup: incremental IPv4 and TCP/UDP checksum fixup
// Path: a word accepted into the input register moves on to the result register
// when that register is free, and leaves it when result_stall is low.
// Throughput: one word per cycle while result_stall is low; the combinational
// add-and-fold of the running sums between the two registers sets it.
// Reset (rst, synchronous): clears both valids, the running sums and the
// configuration registers (ip_header_words returns to 5, others to 0).
// ----------------------------------------------------------------------------
module frame_patch_checksum_fixup (
  input  logic                             clk,
  input  logic                             rst,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fpcf_pkg::ADDR_W-1:0]      paddr,
  input  logic [fpcf_pkg::DATA_W-1:0]      pwdata,
  output logic [fpcf_pkg::DATA_W-1:0]      prdata,
  output logic                             pready,
  // patch words in
  input  logic                             patch_valid,
  output logic                             patch_stall,
  input  logic                             first_of_frame,
  input  logic [fpcf_pkg::OFF_W-1:0]       byte_offset,
  input  logic [fpcf_pkg::WORD_W-1:0]      old_word,
  input  logic [fpcf_pkg::WORD_W-1:0]      new_word,
  // write words out
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [fpcf_pkg::OFF_W-1:0]       out_offset,
  output logic [fpcf_pkg::WORD_W-1:0]      out_word,
  output logic                             write_enable,
  output logic [fpcf_pkg::WORD_W-1:0]      ip_checksum,
  output logic [fpcf_pkg::WORD_W-1:0]      l4_checksum
);

  fpcf_pkg::cfg_t   cfg;
  fpcf_pkg::patch_t patch;
  fpcf_pkg::wr_t    wr;
  logic             patch_held;
  logic             out_ready;
  logic             advance;
  logic             take;

  fpcf_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The result register is free when empty or when its word leaves this edge.
  assign out_ready   = !result_valid || !result_stall;
  // Move the held patch into the result stage whenever that stage is free.
  assign advance     = patch_held && out_ready;
  // Stall the input only when a patch is held and cannot move on.
  assign patch_stall = patch_held && !out_ready;
  assign take        = patch_valid && !patch_stall;

  // Input register: valid bit under reset, payload captured on accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      patch_held <= 1'b0;
    end else if (take) begin
      patch_held <= 1'b1;
    end else if (advance) begin
      patch_held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      patch.first_of_frame <= first_of_frame;
      // drop bit 0: every patch addresses a whole 16-bit word
      patch.offset         <= {byte_offset[fpcf_pkg::OFF_W-1:1], 1'b0};
      patch.old_word       <= old_word;
      patch.new_word       <= new_word;
    end
  end

  // Classification, checksum adjust and the result register.
  fpcf_update u_update (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .patch   (patch),
    .cfg     (cfg),
    .wr      (wr),
    .ip_sum  (ip_checksum),
    .l4_sum  (l4_checksum)
  );

  // Result valid: set on advance, clear when the word is taken downstream.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // The running sums change only on advance, together with the result
  // register, so they always show the sums after the word on display.
  assign out_offset   = wr.offset;
  assign out_word     = wr.word;
  assign write_enable = wr.write_enable;

endmodule

### rtl/fpcf_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpcf_apb_regs: configuration register file
// APB-style write and read of the template and frame-type registers.
// ----------------------------------------------------------------------------
module fpcf_apb_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fpcf_pkg::ADDR_W-1:0]      paddr,
  input  logic [fpcf_pkg::DATA_W-1:0]      pwdata,
  output logic [fpcf_pkg::DATA_W-1:0]      prdata,
  output logic                             pready,
  output fpcf_pkg::cfg_t                   cfg
);

  logic                      wr_en;
  fpcf_pkg::reg_idx_t        idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = fpcf_pkg::reg_idx_t'(paddr[fpcf_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_is_ipv4        <= 1'b0;
      cfg.ip_header_words      <= 4'd5;
      cfg.l4_kind              <= fpcf_pkg::KIND_OTHER;
      cfg.template_ip_checksum <= '0;
      cfg.template_l4_checksum <= '0;
    end else if (wr_en) begin
      case (idx)
        fpcf_pkg::REG_FRAME_IS_IPV4:   cfg.frame_is_ipv4        <= pwdata[0];
        fpcf_pkg::REG_IP_HEADER_WORDS: cfg.ip_header_words      <= pwdata[3:0];
        fpcf_pkg::REG_L4_KIND:         cfg.l4_kind              <= pwdata[1:0];
        fpcf_pkg::REG_TMPL_IP_CSUM:    cfg.template_ip_checksum <= pwdata[15:0];
        fpcf_pkg::REG_TMPL_L4_CSUM:    cfg.template_l4_checksum <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      fpcf_pkg::REG_FRAME_IS_IPV4:   prdata[0]    = cfg.frame_is_ipv4;
      fpcf_pkg::REG_IP_HEADER_WORDS: prdata[3:0]  = cfg.ip_header_words;
      fpcf_pkg::REG_L4_KIND:         prdata[1:0]  = cfg.l4_kind;
      fpcf_pkg::REG_TMPL_IP_CSUM:    prdata[15:0] = cfg.template_ip_checksum;
      fpcf_pkg::REG_TMPL_L4_CSUM:    prdata[15:0] = cfg.template_l4_checksum;
      default:                       prdata       = '0;
    endcase
  end

endmodule

### rtl/fpcf_csum_adj.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpcf_csum_adj: incremental ones'-complement checksum adjust
// Result is ~(~sum + ~old + new) with end-around carries folded twice.
// ----------------------------------------------------------------------------
module fpcf_csum_adj (
  input  logic [fpcf_pkg::WORD_W-1:0] sum,
  input  logic [fpcf_pkg::WORD_W-1:0] old_w,
  input  logic [fpcf_pkg::WORD_W-1:0] new_w,
  output logic [fpcf_pkg::WORD_W-1:0] res
);

  logic [17:0] raw;
  logic [16:0] fold1;
  logic [15:0] fold2;

  // Three 16-bit terms fit in 18 bits; two folds always settle the carry.
  // Complement at 16 bits first, then zero-extend.
  assign raw   = {2'b00, ~sum} + {2'b00, ~old_w} + {2'b00, new_w};
  assign fold1 = 17'(raw[15:0]) + 17'(raw[17:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);
  assign res   = ~fold2;

endmodule

### rtl/fpcf_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpcf_update: patch classifier and running checksum registers
// Decide coverage and drop for one word, adjust both sums, register result.
// ----------------------------------------------------------------------------
module fpcf_update (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  fpcf_pkg::patch_t             patch,
  input  fpcf_pkg::cfg_t               cfg,
  output fpcf_pkg::wr_t                wr,
  output logic [fpcf_pkg::WORD_W-1:0]  ip_sum,
  output logic [fpcf_pkg::WORD_W-1:0]  l4_sum
);

  logic [fpcf_pkg::WORD_W-1:0] ip_base;
  logic [fpcf_pkg::WORD_W-1:0] l4_base;
  logic [fpcf_pkg::WORD_W-1:0] ip_adj;
  logic [fpcf_pkg::WORD_W-1:0] l4_adj;
  logic [fpcf_pkg::WORD_W-1:0] ip_sum_next;
  logic [fpcf_pkg::WORD_W-1:0] l4_sum_next;
  logic [fpcf_pkg::OFF_W-1:0]  l4_off;
  logic                        beyond;
  logic                        in_pseudo;
  logic                        in_ip_hdr;
  logic                        in_l4;
  logic                        we_next;

  assign ip_base = patch.first_of_frame ? cfg.template_ip_checksum : ip_sum;
  assign l4_base = patch.first_of_frame ? cfg.template_l4_checksum : l4_sum;

  fpcf_csum_adj u_ip_adj (
    .sum   (ip_base),
    .old_w (patch.old_word),
    .new_w (patch.new_word),
    .res   (ip_adj)
  );

  fpcf_csum_adj u_l4_adj (
    .sum   (l4_base),
    .old_w (patch.old_word),
    .new_w (patch.new_word),
    .res   (l4_adj)
  );

  assign l4_off    = fpcf_pkg::ETH_HDR_BYTES
                   + {{(fpcf_pkg::OFF_W-6){1'b0}}, cfg.ip_header_words, 2'b00};
  assign beyond    = (32'(patch.offset) > 32'(fpcf_pkg::OFF_LIMIT));
  assign in_pseudo = (patch.offset >= fpcf_pkg::PSEUDO_LO)
                   && (patch.offset < fpcf_pkg::PSEUDO_HI);
  assign in_ip_hdr = (patch.offset >= fpcf_pkg::ETH_HDR_BYTES) && (patch.offset < l4_off);
  assign in_l4     = in_pseudo || (patch.offset >= l4_off);

  always_comb begin
    ip_sum_next = ip_base;
    l4_sum_next = l4_base;
    we_next     = 1'b1;
    if (beyond) begin
      we_next = 1'b0;
    end else if (cfg.frame_is_ipv4) begin
      if (patch.offset == fpcf_pkg::IP_CSUM_OFF) begin
        we_next = 1'b0;
      end else begin
        if (in_ip_hdr) begin
          ip_sum_next = ip_adj;
        end
        unique case (fpcf_pkg::l4_kind_t'(cfg.l4_kind))
          fpcf_pkg::KIND_TCP: begin
            if (patch.offset == l4_off + fpcf_pkg::TCP_CSUM_REL) begin
              we_next = 1'b0;
            end else if (in_l4) begin
              l4_sum_next = l4_adj;
            end
          end
          fpcf_pkg::KIND_UDP: begin
            // a zero UDP checksum means "none" and must stay zero
            if (patch.offset == l4_off + fpcf_pkg::UDP_CSUM_REL) begin
              we_next = 1'b0;
            end else if (in_l4 && (l4_base != '0)) begin
              l4_sum_next = l4_adj;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ip_sum <= '0;
      l4_sum <= '0;
    end else if (advance) begin
      ip_sum <= ip_sum_next;
      l4_sum <= l4_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      wr.offset       <= patch.offset;
      wr.word         <= patch.new_word;
      wr.write_enable <= we_next;
    end
  end

endmodule

### rtl/fpcf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpcf_checker: port-level assertions for the checksum fixup
// Watches the handshake ports and result words; bound to the top level.
// ----------------------------------------------------------------------------
module fpcf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        patch_stall,
  input logic                        result_valid,
  input logic                        result_stall,
  input logic [fpcf_pkg::OFF_W-1:0]  out_offset,
  input logic [fpcf_pkg::WORD_W-1:0] out_word,
  input logic                        write_enable,
  input logic [fpcf_pkg::WORD_W-1:0] ip_checksum,
  input logic [fpcf_pkg::WORD_W-1:0] l4_checksum
);

  // hold a stalled result word
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result word dropped while stalled");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(out_offset) && $stable(out_word)
      && $stable(write_enable) && $stable(ip_checksum) && $stable(l4_checksum))
    else $error("stalled result word changed");

  // input backs up only behind a full result stage
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    patch_stall |-> result_valid)
    else $error("input stalled with empty result stage");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  a_even_offset: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !out_offset[0])
    else $error("odd result offset");

endmodule

bind frame_patch_checksum_fixup fpcf_checker u_fpcf_checker (
  .clk          (clk),
  .rst          (rst),
  .patch_stall  (patch_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .out_offset   (out_offset),
  .out_word     (out_word),
  .write_enable (write_enable),
  .ip_checksum  (ip_checksum),
  .l4_checksum  (l4_checksum)
);
